### sv/vortex_indicator_top_macros.svh
// ----------------------------------------------------------------------------
// Vortex indicator assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VORTEX_INDICATOR_TOP_MACROS_SVH
`define VORTEX_INDICATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a consequent in the same cycle as its antecedent
`define VI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequent in the cycle after its antecedent
`define VI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define VI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### sv/vi_pkg.sv
// ----------------------------------------------------------------------------
// Vortex indicator package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vi_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WINDOW = 256;
    localparam int DEF_PRICE_BITS = 24;

    // Window length register
    localparam int WLEN_W     = 8;
    localparam int DEF_WINDOW = 14;
    localparam int MIN_WINDOW = 2;

    // Ratio format: unsigned Q4.16, difference signed Q4.16 plus sign
    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = 4;
    localparam int RATIO_BITS = INT_BITS + FRAC_BITS;
    localparam int DIFF_BITS  = RATIO_BITS + 1;

    // Result channel packing
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * RATIO_BITS - DIFF_BITS;
    localparam int OUT_USER_W = 2;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } vi_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic update;
        logic div_start;
        logic out_load;
    } vi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } vi_sts_t;

endpackage

### sv/vi_div.sv
// ----------------------------------------------------------------------------
// Vortex indicator divider
// Two-lane restoring divider sharing one divisor: one quotient bit per cycle,
// Q4.16 result with an overflow flag computed at start.
// ----------------------------------------------------------------------------
module vi_div import vi_pkg::*; #(
    parameter int SUM_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SUM_W-1:0]      num_a,
    input  logic [SUM_W-1:0]      num_b,
    input  logic [SUM_W-1:0]      den,
    output logic                  done,
    output logic [RATIO_BITS-1:0] quo_a,
    output logic [RATIO_BITS-1:0] quo_b,
    output logic                  sat_a,
    output logic                  sat_b
);

    localparam int CNT_W = $clog2(RATIO_BITS);

    logic [SUM_W-1:0]      rem_reg  [2];
    logic [SUM_W-1:0]      rem_next [2];
    logic [RATIO_BITS-1:0] bits_reg [2];
    logic [RATIO_BITS-1:0] quo_reg  [2];
    logic                  qbit     [2];
    logic                  sat_reg  [2];
    logic [SUM_W-1:0]      num      [2];
    logic                  sat_next [2];
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    assign num[0] = num_a;
    assign num[1] = num_b;

    // Trial subtract per lane and overflow test at start
    always_comb begin
        logic [SUM_W:0] shifted;
        logic [SUM_W:0] trial;
        for (int i = 0; i < 2; i++) begin
            shifted     = {rem_reg[i], bits_reg[i][RATIO_BITS-1]};
            trial       = shifted - {1'b0, den};
            qbit[i]     = ~trial[SUM_W];
            rem_next[i] = trial[SUM_W] ? shifted[SUM_W-1:0] : trial[SUM_W-1:0];
            sat_next[i] = {{INT_BITS{1'b0}}, num[i]} >= {den, {INT_BITS{1'b0}}};
        end
    end

    // Iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RATIO_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift in one quotient bit per cycle
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            if (start) begin
                rem_reg[i]  <= num[i] >> INT_BITS;
                bits_reg[i] <= {num[i][INT_BITS-1:0], {FRAC_BITS{1'b0}}};
                quo_reg[i]  <= '0;
                sat_reg[i]  <= sat_next[i];
            end else if (busy_reg) begin
                rem_reg[i]  <= rem_next[i];
                bits_reg[i] <= {bits_reg[i][RATIO_BITS-2:0], 1'b0};
                quo_reg[i]  <= {quo_reg[i][RATIO_BITS-2:0], qbit[i]};
            end
        end
    end

    assign done  = done_reg;
    assign quo_a = quo_reg[0];
    assign quo_b = quo_reg[1];
    assign sat_a = sat_reg[0];
    assign sat_b = sat_reg[1];

endmodule

### sv/vi_ctrl.sv
// ----------------------------------------------------------------------------
// Vortex indicator controller
// Sequences one bar through term capture, window update, division and the
// result register, and drives the stream handshakes.
// ----------------------------------------------------------------------------
`include "vortex_indicator_top_macros.svh"

module vi_ctrl import vi_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  vi_sts_t sts,
    output vi_cmd_t cmd
);

    vi_state_t state_reg;
    vi_state_t state_next;
    logic      m_tvalid_reg;
    logic      m_tvalid_next;

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SUM;
                end
            end
            S_SUM: begin
                cmd.update = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `VI_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    `VI_ASSERT_SAME(a_out_free, aclk, aresetn, cmd.out_load, !m_tvalid_reg || m_tready, "result overwritten")
    `VI_ASSERT_SAME(a_done_in_div, aclk, aresetn, sts.div_done, state_reg == S_DIV, "stray divider done")

endmodule

### sv/vi_dp.sv
// ----------------------------------------------------------------------------
// Vortex indicator datapath
// Previous bar, per-bar terms, term ring memory, window sums, divider and
// result register.
// ----------------------------------------------------------------------------
module vi_dp import vi_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [WLEN_W-1:0]           cfg_wr_data,
    input  logic [PRICE_BITS-1:0]       high_price,
    input  logic [PRICE_BITS-1:0]       low_price,
    input  logic [PRICE_BITS-1:0]       close_price,
    input  vi_cmd_t                     cmd,
    output vi_sts_t                     sts,
    output logic [RATIO_BITS-1:0]       vi_plus,
    output logic [RATIO_BITS-1:0]       vi_minus,
    output logic signed [DIFF_BITS-1:0] vi_difference,
    output logic                        window_full,
    output logic                        zero_range
);

    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
    localparam int SUM_W   = PRICE_BITS + PTR_W;
    localparam int ENTRY_W = 3 * PRICE_BITS;

    logic [WLEN_W-1:0]     window_length_reg;
    logic [CMP_W-1:0]      wl_ext;
    logic [LEN_W-1:0]      eff_len;

    logic                  prev_valid_reg;
    logic [PRICE_BITS-1:0] prev_high_reg;
    logic [PRICE_BITS-1:0] prev_low_reg;
    logic [PRICE_BITS-1:0] prev_close_reg;
    logic [PRICE_BITS-1:0] ph, pl, pc, top, bot;
    logic [PRICE_BITS-1:0] up_term, dn_term, tr_term;
    logic [PRICE_BITS-1:0] up_reg, dn_reg, tr_reg;

    logic [ENTRY_W-1:0]    ring_mem [MAX_WINDOW];
    logic [ENTRY_W-1:0]    rd_entry_reg;
    logic [ENTRY_W-1:0]    old_entry;

    logic [SUM_W-1:0]      up_sum_reg, dn_sum_reg, tr_sum_reg;
    logic [PTR_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      pos_inc;
    logic [LEN_W-1:0]      bars_seen_reg;
    logic                  full_now;

    logic                  div_done;
    logic [RATIO_BITS-1:0] quo_a, quo_b;
    logic                  sat_a, sat_b;
    logic [RATIO_BITS-1:0] vp, vm;

    logic [RATIO_BITS-1:0] vp_reg, vm_reg;
    logic [DIFF_BITS-1:0]  diff_reg;
    logic                  full_reg, zero_reg;

    // Clamp the window length to the supported range
    always_comb begin
        wl_ext = CMP_W'(window_length_reg);
        if (wl_ext < CMP_W'(MIN_WINDOW)) begin
            eff_len = LEN_W'(MIN_WINDOW);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = wl_ext[LEN_W-1:0];
        end
    end

    // Per-bar terms; the first bar stands in for its own predecessor
    always_comb begin
        ph      = prev_valid_reg ? prev_high_reg  : high_price;
        pl      = prev_valid_reg ? prev_low_reg   : low_price;
        pc      = prev_valid_reg ? prev_close_reg : close_price;
        up_term = (high_price >= pl) ? high_price - pl : pl - high_price;
        dn_term = (low_price >= ph) ? low_price - ph : ph - low_price;
        top     = (high_price > pc) ? high_price : pc;
        bot     = (low_price < pc) ? low_price : pc;
        tr_term = top - bot;
    end

    // Capture terms and the previous bar
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else if (cmd.load_in) begin
            prev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            up_reg         <= up_term;
            dn_reg         <= dn_term;
            tr_reg         <= tr_term;
            prev_high_reg  <= high_price;
            prev_low_reg   <= low_price;
            prev_close_reg <= close_price;
        end
    end

    // Term ring: read the leaving slot on capture, overwrite it on update
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            rd_entry_reg <= ring_mem[pos_reg];
        end
        if (cmd.update) begin
            ring_mem[pos_reg] <= {tr_reg, dn_reg, up_reg};
        end
    end

    // A slot holds data only once the window has filled since the last clear
    assign full_now  = (bars_seen_reg == eff_len);
    assign old_entry = full_now ? rd_entry_reg : '0;
    assign pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);

    // Window sums, ring position and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WLEN_W'(DEF_WINDOW);
            up_sum_reg        <= '0;
            dn_sum_reg        <= '0;
            tr_sum_reg        <= '0;
            pos_reg           <= '0;
            bars_seen_reg     <= '0;
        end else if (cfg_wr_en) begin
            window_length_reg <= cfg_wr_data;
            up_sum_reg        <= '0;
            dn_sum_reg        <= '0;
            tr_sum_reg        <= '0;
            pos_reg           <= '0;
            bars_seen_reg     <= '0;
        end else if (cmd.update) begin
            up_sum_reg <= up_sum_reg + SUM_W'(up_reg)
                          - SUM_W'(old_entry[PRICE_BITS-1:0]);
            dn_sum_reg <= dn_sum_reg + SUM_W'(dn_reg)
                          - SUM_W'(old_entry[2*PRICE_BITS-1:PRICE_BITS]);
            tr_sum_reg <= tr_sum_reg + SUM_W'(tr_reg)
                          - SUM_W'(old_entry[3*PRICE_BITS-1:2*PRICE_BITS]);
            pos_reg    <= (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
            if (!full_now) begin
                bars_seen_reg <= bars_seen_reg + LEN_W'(1);
            end
        end
    end

    vi_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_a   (up_sum_reg),
        .num_b   (dn_sum_reg),
        .den     (tr_sum_reg),
        .done    (div_done),
        .quo_a   (quo_a),
        .quo_b   (quo_b),
        .sat_a   (sat_a),
        .sat_b   (sat_b)
    );

    assign sts.div_done = div_done;

    // Saturate ratios; a zero range sum forces both to zero
    always_comb begin
        if (tr_sum_reg == '0) begin
            vp = '0;
            vm = '0;
        end else begin
            vp = sat_a ? {RATIO_BITS{1'b1}} : quo_a;
            vm = sat_b ? {RATIO_BITS{1'b1}} : quo_b;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            vp_reg   <= vp;
            vm_reg   <= vm;
            diff_reg <= {1'b0, vp} - {1'b0, vm};
            full_reg <= full_now;
            zero_reg <= (tr_sum_reg == '0);
        end
    end

    assign vi_plus       = vp_reg;
    assign vi_minus      = vm_reg;
    assign vi_difference = $signed(diff_reg);
    assign window_full   = full_reg;
    assign zero_range    = zero_reg;

endmodule

### sv/vortex_indicator_top.sv
// ----------------------------------------------------------------------------
// Vortex indicator top level
// Bars enter on s_tvalid/s_tready/s_tdata (high, low, close in ticks); one
// result per bar leaves on m_tvalid/m_tready/m_tdata/m_tuser with VI+, VI-
// (unsigned Q4.16) and their difference, plus window-full and zero-range flags.
// cfg_wr_en/cfg_wr_data write the window length (2..255) and restart the window;
// write it only while no bar is in flight.
// Each bar is captured, added to the window, divided and loaded into the result
// register before the next bar is taken. The two 20-bit serial divisions run side
// by side, one quotient bit per cycle.
// A finished result sits in an output register, so one more bar is accepted while
// the receiver stalls; that bar's result waits in the divider until the register
// is free, and no further bar is taken meanwhile.
// Reset clears the window, the sums and the previous-bar marker and sets the
// window length to 14. The term ring is not cleared: a fill count keeps stale
// slots out of the sums, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module vortex_indicator_top import vi_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS,
    localparam int IN_DATA_W = ((3 * PRICE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Window length register
    input  logic                  cfg_wr_en,
    input  logic [WLEN_W-1:0]     cfg_wr_data,
    // Bar requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // high_price, low_price, close_price, zero pad
    // Result requests
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // vi_plus, vi_minus, vi_difference, zero pad
    output logic [OUT_USER_W-1:0] m_tuser    // window_full, zero_range
);

    vi_cmd_t                     cmd;
    vi_sts_t                     sts;
    logic [RATIO_BITS-1:0]       vi_plus;
    logic [RATIO_BITS-1:0]       vi_minus;
    logic signed [DIFF_BITS-1:0] vi_difference;
    logic                        window_full;
    logic                        zero_range;

    vi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vi_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .high_price    (s_tdata[PRICE_BITS-1:0]),
        .low_price     (s_tdata[2*PRICE_BITS-1:PRICE_BITS]),
        .close_price   (s_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
        .cmd           (cmd),
        .sts           (sts),
        .vi_plus       (vi_plus),
        .vi_minus      (vi_minus),
        .vi_difference (vi_difference),
        .window_full   (window_full),
        .zero_range    (zero_range)
    );

    // Pack the result
    assign m_tdata = {{OUT_PAD_W{1'b0}}, vi_difference, vi_minus, vi_plus};
    assign m_tuser = {zero_range, window_full};

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Vortex indicator regression bench
// Sends price-bar requests to the block and predicts every result request
// from a software copy of the window rings and sums. Results are compared
// field by field in arrival order. The window length is reprogrammed between
// phases, and both stream sides are throttled at changing rates.
// ----------------------------------------------------------------------------
module tb_top import vi_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int PRICE_W       = DEF_PRICE_BITS;
    localparam int BAR_W         = ((3 * PRICE_W + 7) / 8) * 8;
    localparam logic [PRICE_W-1:0]    PRICE_MAX = '1;
    localparam logic [RATIO_BITS-1:0] RATIO_SAT = '1;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int IDLE_LIGHT    = 17;
    localparam int IDLE_HEAVY    = 72;
    localparam int MAX_GAP       = 40;
    localparam int LEN_RANDOM    = -1;
    localparam int LEN_TOP       = 200;
    localparam int PHASES        = 8;
    localparam int DIRECTED_BARS = 16;
    localparam int PACE_SWITCH_A = 633;
    localparam int PACE_SWITCH_B = 1266;

    typedef struct packed {
        logic [RATIO_BITS-1:0] vi_plus;
        logic [RATIO_BITS-1:0] vi_minus;
        logic [DIFF_BITS-1:0]  vi_difference;
        logic                  window_full;
        logic                  zero_range;
    } vortex_result_t;

    typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} pace_t;

    // Window predictor and queue of expected vortex results
    class vortex_scoreboard;
        logic [WLEN_W-1:0]  length_reg;
        logic [PRICE_W-1:0] up_ring[DEF_MAX_WINDOW];
        logic [PRICE_W-1:0] down_ring[DEF_MAX_WINDOW];
        logic [PRICE_W-1:0] range_ring[DEF_MAX_WINDOW];
        longint unsigned    up_total;
        longint unsigned    down_total;
        longint unsigned    range_total;
        int unsigned        slot;
        int unsigned        filled;
        logic               prev_valid;
        logic [PRICE_W-1:0] prev_high;
        logic [PRICE_W-1:0] prev_low;
        logic [PRICE_W-1:0] prev_close;
        vortex_result_t     pending_vortex[$];
        int unsigned        failures;
        int unsigned        results_checked;
        int unsigned        zero_range_seen;
        int unsigned        saturated_seen;
        int unsigned        full_seen;

        function new();
            length_reg      = WLEN_W'(DEF_WINDOW);
            prev_valid      = 1'b0;
            prev_high       = '0;
            prev_low        = '0;
            prev_close      = '0;
            failures        = 0;
            results_checked = 0;
            zero_range_seen = 0;
            saturated_seen  = 0;
            full_seen       = 0;
            restart_window();
        endfunction

        // Drop all window history; the previous bar survives
        function void restart_window();
            foreach (up_ring[i]) begin
                up_ring[i]    = '0;
                down_ring[i]  = '0;
                range_ring[i] = '0;
            end
            up_total    = 0;
            down_total  = 0;
            range_total = 0;
            slot        = 0;
            filled      = 0;
        endfunction

        function void set_length(logic [WLEN_W-1:0] len);
            length_reg = len;
            restart_window();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ERROR %s", $time, msg);
        endfunction

        // Q4.16 quotient, truncated and saturated
        function logic [RATIO_BITS-1:0] ratio_q16(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = (num << FRAC_BITS) / den;
            return (q > RATIO_SAT) ? RATIO_SAT : q[RATIO_BITS-1:0];
        endfunction

        // Advance the window by one accepted bar and queue its result
        function void note_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                               logic [PRICE_W-1:0] cl);
            logic [PRICE_W-1:0] ph, pl, pc, up, down, top, bottom, tr;
            int unsigned span;
            vortex_result_t r;
            span = length_reg;
            if (span < MIN_WINDOW)
                span = MIN_WINDOW;
            if (span > DEF_MAX_WINDOW)
                span = DEF_MAX_WINDOW;
            // the first bar after reset stands in for its own predecessor
            if (prev_valid) begin
                ph = prev_high;
                pl = prev_low;
                pc = prev_close;
            end else begin
                ph = hi;
                pl = lo;
                pc = cl;
            end
            up     = (hi >= pl) ? hi - pl : pl - hi;
            down   = (lo >= ph) ? lo - ph : ph - lo;
            top    = (hi > pc) ? hi : pc;
            bottom = (lo < pc) ? lo : pc;
            tr     = top - bottom;
            if (slot >= span)
                slot = 0;
            up_total          = up_total - up_ring[slot] + up;
            down_total        = down_total - down_ring[slot] + down;
            range_total       = range_total - range_ring[slot] + tr;
            up_ring[slot]     = up;
            down_ring[slot]   = down;
            range_ring[slot]  = tr;
            slot              = (slot + 1 >= span) ? 0 : slot + 1;
            if (filled < span)
                filled++;
            prev_valid = 1'b1;
            prev_high  = hi;
            prev_low   = lo;
            prev_close = cl;
            r = '0;
            r.zero_range = (range_total == 0);
            if (!r.zero_range) begin
                r.vi_plus       = ratio_q16(up_total, range_total);
                r.vi_minus      = ratio_q16(down_total, range_total);
                r.vi_difference = {1'b0, r.vi_plus} - {1'b0, r.vi_minus};
            end
            r.window_full = (filled >= span);
            pending_vortex.push_back(r);
        endfunction

        // Compare one result request with the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            vortex_result_t want, got;
            got.vi_plus       = data[RATIO_BITS-1:0];
            got.vi_minus      = data[2*RATIO_BITS-1:RATIO_BITS];
            got.vi_difference = data[2*RATIO_BITS+DIFF_BITS-1:2*RATIO_BITS];
            got.window_full   = user[0];
            got.zero_range    = user[1];
            results_checked++;
            if (pending_vortex.size() == 0) begin
                report("result arrived with no bar outstanding");
                return;
            end
            want = pending_vortex.pop_front();
            if (want.zero_range)
                zero_range_seen++;
            if (want.window_full)
                full_seen++;
            if (want.vi_plus == RATIO_SAT || want.vi_minus == RATIO_SAT)
                saturated_seen++;
            if (got.vi_plus !== want.vi_plus || got.vi_minus !== want.vi_minus ||
                got.vi_difference !== want.vi_difference ||
                got.window_full !== want.window_full ||
                got.zero_range !== want.zero_range)
                report($sformatf({"result %0d exp/act: vi_plus %h/%h vi_minus %h/%h ",
                                  "diff %h/%h full %b/%b zero %b/%b"},
                                 results_checked, want.vi_plus, got.vi_plus,
                                 want.vi_minus, got.vi_minus,
                                 want.vi_difference, got.vi_difference,
                                 want.window_full, got.window_full,
                                 want.zero_range, got.zero_range));
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [WLEN_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [BAR_W-1:0]      s_tdata     = '0;   // high_price, low_price, close_price
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // vi_plus, vi_minus, vi_difference, pad
    logic [OUT_USER_W-1:0] m_tuser;            // window_full, zero_range

    vortex_scoreboard vortex_sb = new();
    pace_t            pace      = PACE_SLOW_SINK;
    int unsigned      bars_sent = 0;
    int unsigned      lengths_used = 0;
    longint           walk_level = 0;
    int unsigned      walk_bits  = 4;
    int unsigned      flat_left  = 0;

    // Edge cases first: first bar, flat and inverted bars, one-tick range, extremes
    logic [PRICE_W-1:0] directed_bars[DIRECTED_BARS][3] = '{
        '{24'd5000,   24'd5000,   24'd5000},
        '{24'd5000,   24'd5000,   24'd5000},
        '{24'd0,      24'hFFFFFF, 24'd5000},
        '{24'd5001,   24'hFFFFFF, 24'd5001},
        '{24'd5001,   24'd5001,   24'd5001},
        '{24'hFFFFFF, 24'd0,      24'h800000},
        '{24'd0,      24'd0,      24'd0},
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        '{24'hFFFFFF, 24'd0,      24'd0},
        '{24'd0,      24'hFFFFFF, 24'hFFFFFF},
        '{24'hAAAAAA, 24'h555555, 24'hAAAAAA},
        '{24'h555555, 24'hAAAAAA, 24'h555555},
        '{24'd100100, 24'd100000, 24'd100050},
        '{24'd100200, 24'd100080, 24'd100150},
        '{24'd100150, 24'd100020, 24'd100040},
        '{24'd100300, 24'd100100, 24'd100280}
    };

    int unsigned phase_bars[PHASES]   = '{250, 150, 400, 100, 100, 350, 250, 300};
    int          phase_length[PHASES] = '{DEF_WINDOW, 2, 255, 0, 1, LEN_TOP,
                                          LEN_RANDOM, LEN_RANDOM};

    vortex_indicator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int unsigned pace_idle(pace_t p, bit sink);
        case (p)
            PACE_SLOW_SINK:   return sink ? IDLE_HEAVY : IDLE_LIGHT;
            PACE_SLOW_SOURCE: return sink ? IDLE_LIGHT : IDLE_HEAVY;
            default:          return 0;
        endcase
    endfunction

    function automatic logic [PRICE_W-1:0] clamp_price(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(PRICE_MAX))
            return PRICE_MAX;
        return v[PRICE_W-1:0];
    endfunction

    // Check each result request and throttle ready at the current pace
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            vortex_sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= pace_idle(pace, 1'b1));
    end

    // Hold one bar request until it is taken, after an optional idle gap
    task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                            input logic [PRICE_W-1:0] cl);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(0, 99) < pace_idle(pace, 1'b0))
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= BAR_W'({cl, lo, hi});
        do @(posedge aclk); while (!s_tready);
        vortex_sb.note_bar(hi, lo, cl);
        bars_sent++;
        if (bars_sent >= PACE_SWITCH_B)
            pace = PACE_FREE;
        else if (bars_sent >= PACE_SWITCH_A)
            pace = PACE_SLOW_SOURCE;
    endtask

    // Reprogram the window once every result has drained
    task automatic write_length(input logic [WLEN_W-1:0] len);
        s_tvalid <= 1'b0;
        while (vortex_sb.pending_vortex.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vortex_sb.set_length(len);
        lengths_used++;
    endtask

    // Mostly random-walk bars, with flat runs, noise and extreme prices mixed in
    task automatic make_bar(output logic [PRICE_W-1:0] hi, output logic [PRICE_W-1:0] lo,
                            output logic [PRICE_W-1:0] cl);
        int unsigned kind, spread;
        longint center, h, l;
        kind = $urandom_range(0, 99);
        if (flat_left == 0 && kind < 5)
            flat_left = $urandom_range(1, 20);
        if (flat_left > 0) begin
            flat_left--;
            hi = clamp_price(walk_level);
            lo = hi;
            cl = hi;
        end else if (kind < 80) begin
            spread     = $urandom_range(0, 1 << walk_bits);
            center     = walk_level + longint'($urandom_range(0, 2 * spread)) - spread;
            h          = center + $urandom_range(0, spread);
            l          = center - $urandom_range(0, spread);
            hi         = clamp_price(h);
            lo         = clamp_price(l);
            cl         = lo + PRICE_W'($urandom_range(0, hi - lo));
            walk_level = clamp_price(center);
        end else if (kind < 93) begin
            hi = PRICE_W'($urandom);
            lo = PRICE_W'($urandom);
            cl = PRICE_W'($urandom);
        end else begin
            hi = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX
                                                                           : PRICE_W'($urandom));
            lo = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX
                                                                           : PRICE_W'($urandom));
            cl = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? PRICE_MAX
                                                                           : PRICE_W'($urandom));
        end
    endtask

    // Reset, directed bars, then one random phase per window setting
    initial begin : stimulus
        logic [PRICE_W-1:0] hi, lo, cl;
        int unsigned first_item;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        walk_level = $urandom_range(0, PRICE_MAX);
        foreach (directed_bars[i])
            send_bar(directed_bars[i][0], directed_bars[i][1], directed_bars[i][2]);
        for (int p = 0; p < PHASES; p++) begin
            first_item = 0;
            if (p == 0)
                first_item = DIRECTED_BARS;
            else if (phase_length[p] == LEN_RANDOM)
                write_length(WLEN_W'($urandom_range(MIN_WINDOW, LEN_TOP)));
            else
                write_length(WLEN_W'(phase_length[p]));
            walk_bits = $urandom_range(0, 16);
            for (int unsigned n = first_item; n < phase_bars[p]; n++) begin
                make_bar(hi, lo, cl);
                send_bar(hi, lo, cl);
            end
        end
        s_tvalid <= 1'b0;
        while (vortex_sb.pending_vortex.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d bars across %0d window writes; %0d results checked",
                 bars_sent, lengths_used, vortex_sb.results_checked);
        $display("Results: %0d full-window, %0d zero-range, %0d saturated; %0d failures",
                 vortex_sb.full_seen, vortex_sb.zero_range_seen,
                 vortex_sb.saturated_seen, vortex_sb.failures);
        if (vortex_sb.failures == 0)
            $display("vortex_indicator_top regression: pass");
        else
            $display("vortex_indicator_top regression: fail");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns with %0d results outstanding", TIMEOUT_NS,
                 vortex_sb.pending_vortex.size());
        $display("vortex_indicator_top regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/vi_pkg.sv
sv/vi_div.sv
sv/vi_ctrl.sv
sv/vi_dp.sv
sv/vortex_indicator_top.sv
tb/sv/tb_top.sv
